[src/assert_macros.svh]
// Assertion macros shared by the altitude PID / mixer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds at an edge -> post holds at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

// pre holds at an edge -> post holds at the same edge
`define ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

`endif

[src/qapm_pkg.sv]
// Package for the altitude PID / quad X mixer: item types, register map,
// sequencer states and saturation helpers. No dependencies.
package qapm_pkg;

    typedef struct packed {
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_rate;
        logic signed [31:0] pitch_rate;
        logic signed [31:0] measured_altitude;
        logic signed [31:0] setpoint_altitude;
        logic signed [31:0] roll_offset;
        logic signed [31:0] pitch_offset;
        logic signed [31:0] yaw_offset;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] front_left_drive;
        logic signed [31:0] front_right_drive;
        logic signed [31:0] rear_left_drive;
        logic signed [31:0] rear_right_drive;
        logic signed [31:0] vertical_command;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] alt_gain_p;
        logic signed [31:0] alt_gain_i;
        logic signed [31:0] alt_gain_d;
        logic signed [31:0] roll_gain;
        logic signed [31:0] pitch_gain;
        logic signed [31:0] base_thrust;
        logic [30:0]        step_seconds;
        logic [30:0]        step_reciprocal;
    } t_cfg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALT_GAIN_P      = 4'd0,
        REG_ALT_GAIN_I      = 4'd1,
        REG_ALT_GAIN_D      = 4'd2,
        REG_ROLL_GAIN       = 4'd3,
        REG_PITCH_GAIN      = 4'd4,
        REG_BASE_THRUST     = 4'd5,
        REG_STEP_SECONDS    = 4'd6,
        REG_STEP_RECIPROCAL = 4'd7
    } t_reg_idx;

    localparam logic [30:0] STEP_SECONDS_RST    = 31'd2097;
    localparam logic [30:0] STEP_RECIPROCAL_RST = 31'd2048000;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
        S_MIX
    } t_state;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
    localparam logic signed [49:0] S48_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] S48_MIN = -50'sd140737488355328;
    localparam logic signed [31:0] ANGLE_HI = 32'sd65536;
    localparam logic signed [31:0] ANGLE_LO = -32'sd65536;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = S32_MAX[31:0];
        end else if (v < S32_MIN) begin
            res = S32_MIN[31:0];
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] res;
        if (v > S48_MAX) begin
            res = S48_MAX[47:0];
        end else if (v < S48_MIN) begin
            res = S48_MIN[47:0];
        end else begin
            res = v[47:0];
        end
        return res;
    endfunction

    // clamp an angle to +-1.0 in Q16.16; result fits 18 bits signed
    function automatic logic signed [17:0] clamp_unit(input logic signed [31:0] v);
        logic signed [17:0] res;
        if (v > ANGLE_HI) begin
            res = ANGLE_HI[17:0];
        end else if (v < ANGLE_LO) begin
            res = ANGLE_LO[17:0];
        end else begin
            res = v[17:0];
        end
        return res;
    endfunction

endpackage

[src/qapm_if.sv]
// Valid/ready channel interfaces: input item, result item, config write.
// Depends on qapm_pkg.
interface qapm_item_if;
    logic                valid;
    logic                ready;
    qapm_pkg::t_in_item  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface qapm_result_if;
    logic                valid;
    logic                ready;
    qapm_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface qapm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [qapm_pkg::CFG_IDX_W-1:0]     index;
    logic [qapm_pkg::CFG_DATA_W-1:0]    data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

[src/quad_altitude_pid_mixer_core.sv]
// From the accepting edge the sequencer runs S_ERR, S_M1..S_M9, then S_MIX,
// which registers the result. Items are taken only in S_IDLE, one at a time;
// eight products share the single multiplier in turn, under a 12-state sequencer.
// A result waiting at the output stalls only the final mix step.
// Reset (synchronous, active low): integral and last error cleared,
// registers to their defaults, no output pending. No clearing pass.
`include "assert_macros.svh"

module quad_altitude_pid_mixer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qapm_item_if.sink      i_item,
    qapm_result_if.source  o_result,
    qapm_cfg_if.sink       i_cfg
);

    qapm_pkg::t_cfg      cfg;
    qapm_pkg::t_state    r_state, n_state;
    qapm_pkg::t_in_item  r_in;
    qapm_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic signed [47:0]  r_integ;
    logic signed [31:0]  r_last;
    logic signed [31:0]  r_err, r_diff, r_p, r_i, r_deriv, r_d, r_roll, r_pitch, r_v;
    logic signed [63:0]  r_ihi;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod;
    logic signed [49:0]  prod_q;
    logic                in_ready;
    logic                in_fire;
    logic                mix_go;
    logic signed [65:0]  mix_base, mix_fl, mix_fr, mix_rl, mix_rr;

    qapm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    qapm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // floor(product / 2^16)
    assign prod_q = prod[65:16];

    assign i_item.ready   = in_ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    assign in_fire = i_item.valid && in_ready;
    assign mix_go = (r_state == qapm_pkg::S_MIX) && (!r_out_valid || o_result.ready);

    // sequencer: next state, ready and multiplier operand select
    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (r_state)
            qapm_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (i_item.valid) n_state = qapm_pkg::S_ERR;
            end
            qapm_pkg::S_ERR: n_state = qapm_pkg::S_M1;
            qapm_pkg::S_M1: begin
                mul_a   = {r_err[31], r_err};
                mul_b   = $signed({2'b00, cfg.step_seconds});
                n_state = qapm_pkg::S_M2;
            end
            qapm_pkg::S_M2: begin
                mul_a   = {cfg.alt_gain_p[31], cfg.alt_gain_p};
                mul_b   = {r_err[31], r_err};
                n_state = qapm_pkg::S_M3;
            end
            qapm_pkg::S_M3: begin
                // upper part of the 48-bit integral
                mul_a   = {cfg.alt_gain_i[31], cfg.alt_gain_i};
                mul_b   = {r_integ[47], r_integ[47:16]};
                n_state = qapm_pkg::S_M4;
            end
            qapm_pkg::S_M4: begin
                // low 16 bits, unsigned
                mul_a   = {cfg.alt_gain_i[31], cfg.alt_gain_i};
                mul_b   = $signed({17'd0, r_integ[15:0]});
                n_state = qapm_pkg::S_M5;
            end
            qapm_pkg::S_M5: begin
                mul_a   = {r_diff[31], r_diff};
                mul_b   = $signed({2'b00, cfg.step_reciprocal});
                n_state = qapm_pkg::S_M6;
            end
            qapm_pkg::S_M6: begin
                mul_a   = {cfg.roll_gain[31], cfg.roll_gain};
                mul_b   = 33'(qapm_pkg::clamp_unit(r_in.roll_angle));
                n_state = qapm_pkg::S_M7;
            end
            qapm_pkg::S_M7: begin
                mul_a   = {cfg.alt_gain_d[31], cfg.alt_gain_d};
                mul_b   = {r_deriv[31], r_deriv};
                n_state = qapm_pkg::S_M8;
            end
            qapm_pkg::S_M8: begin
                mul_a   = {cfg.pitch_gain[31], cfg.pitch_gain};
                mul_b   = 33'(qapm_pkg::clamp_unit(r_in.pitch_angle));
                n_state = qapm_pkg::S_M9;
            end
            qapm_pkg::S_M9: n_state = qapm_pkg::S_MIX;
            qapm_pkg::S_MIX: begin
                if (mix_go) n_state = qapm_pkg::S_IDLE;
            end
            default: n_state = qapm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qapm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // S_M2 to S_M9 each consume the product issued by the state before them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else begin
            case (r_state)
                qapm_pkg::S_IDLE: begin
                    if (i_item.valid) r_in <= i_item.data;
                end
                qapm_pkg::S_ERR: r_err <= qapm_pkg::sat32(
                    66'(r_in.setpoint_altitude) - 66'(r_in.measured_altitude));
                qapm_pkg::S_M1: r_diff <= qapm_pkg::sat32(66'(r_err) - 66'(r_last));
                qapm_pkg::S_M2: r_integ <= qapm_pkg::sat48(50'(r_integ) + prod_q);
                qapm_pkg::S_M3: r_p <= qapm_pkg::sat32(66'(prod_q));
                qapm_pkg::S_M4: r_ihi <= prod[63:0];
                qapm_pkg::S_M5: r_i <= qapm_pkg::sat32(66'(r_ihi) + 66'(prod_q));
                qapm_pkg::S_M6: r_deriv <= qapm_pkg::sat32(66'(prod_q));
                qapm_pkg::S_M7: r_roll <= qapm_pkg::sat32(
                    66'(prod_q) + 66'(r_in.roll_rate) + 66'(r_in.roll_offset));
                qapm_pkg::S_M8: r_d <= qapm_pkg::sat32(66'(prod_q));
                qapm_pkg::S_M9: begin
                    r_pitch <= qapm_pkg::sat32(
                        66'(prod_q) + 66'(r_in.pitch_rate) + 66'(r_in.pitch_offset));
                    r_v <= qapm_pkg::sat32(66'(r_p) + 66'(r_i) + 66'(r_d));
                end
                qapm_pkg::S_MIX: begin
                    if (mix_go) r_last <= r_err;
                end
                default: ;
            endcase
        end
    end

    // quad X mix, formed exactly before saturation
    always_comb begin
        mix_base = 66'(cfg.base_thrust) + 66'(r_v);
        mix_fl = mix_base - 66'(r_roll) + 66'(r_pitch) - 66'(r_in.yaw_offset);
        mix_fr = -(mix_base + 66'(r_roll) + 66'(r_pitch) + 66'(r_in.yaw_offset));
        mix_rl = -(mix_base - 66'(r_roll) - 66'(r_pitch) + 66'(r_in.yaw_offset));
        mix_rr = mix_base + 66'(r_roll) - 66'(r_pitch) - 66'(r_in.yaw_offset);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mix_go) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mix_go) begin
            r_out.front_left_drive  <= qapm_pkg::sat32(mix_fl);
            r_out.front_right_drive <= qapm_pkg::sat32(mix_fr);
            r_out.rear_left_drive   <= qapm_pkg::sat32(mix_rl);
            r_out.rear_right_drive  <= qapm_pkg::sat32(mix_rr);
            r_out.vertical_command  <= r_v;
        end
    end

    `ASSERT_NEXT(a_accept_starts_seq, i_clk, i_rst_n, in_fire, r_state == qapm_pkg::S_ERR)
    `ASSERT_SAME(a_rise_mix, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == qapm_pkg::S_MIX)
    `ASSERT_NEXT(a_mix_delivers, i_clk, i_rst_n, mix_go, r_out_valid && r_state == qapm_pkg::S_IDLE)

endmodule

[src/qapm_cfg.sv]
// Configuration register file for the altitude PID / mixer.
// Depends on qapm_pkg and qapm_cfg_if.
module qapm_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qapm_cfg_if.sink          i_cfg,
    output qapm_pkg::t_cfg    o_cfg
);

    qapm_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alt_gain_p      <= '0;
            r_cfg.alt_gain_i      <= '0;
            r_cfg.alt_gain_d      <= '0;
            r_cfg.roll_gain       <= '0;
            r_cfg.pitch_gain      <= '0;
            r_cfg.base_thrust     <= '0;
            r_cfg.step_seconds    <= qapm_pkg::STEP_SECONDS_RST;
            r_cfg.step_reciprocal <= qapm_pkg::STEP_RECIPROCAL_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                qapm_pkg::REG_ALT_GAIN_P:      r_cfg.alt_gain_p      <= i_cfg.data;
                qapm_pkg::REG_ALT_GAIN_I:      r_cfg.alt_gain_i      <= i_cfg.data;
                qapm_pkg::REG_ALT_GAIN_D:      r_cfg.alt_gain_d      <= i_cfg.data;
                qapm_pkg::REG_ROLL_GAIN:       r_cfg.roll_gain       <= i_cfg.data;
                qapm_pkg::REG_PITCH_GAIN:      r_cfg.pitch_gain      <= i_cfg.data;
                qapm_pkg::REG_BASE_THRUST:     r_cfg.base_thrust     <= i_cfg.data;
                qapm_pkg::REG_STEP_SECONDS:    r_cfg.step_seconds    <= i_cfg.data[30:0];
                qapm_pkg::REG_STEP_RECIPROCAL: r_cfg.step_reciprocal <= i_cfg.data[30:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

endmodule

[src/qapm_mul.sv]
// Shared 33x33 signed multiplier with a registered product.
// No dependencies.
module qapm_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod
);

    logic signed [65:0] r_prod;
    logic signed [65:0] n_prod;

    assign n_prod = i_a * i_b;
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

endmodule
